// ===== design/urc_pkg.sv =====
// ----------------------------------------------------------------------------
// urc_pkg
// Shared types and constants for the ultrasonic ranger controller.
// ----------------------------------------------------------------------------
package urc_pkg;

  localparam int TIME_BITS_DEFAULT = 24;

  localparam int WIDTH_W = 24;
  localparam int DIST_W  = 27;
  localparam int TRIG_W  = 8;
  localparam int TOUT_W  = 24;
  localparam int CFG_W   = 24;
  localparam int IDX_W   = 2;

  localparam int FACTOR_W = 11;
  localparam logic [FACTOR_W-1:0] DIST_FACTOR = FACTOR_W'(1124);
  localparam int DIST_SHIFT = 8;

  localparam logic [TRIG_W-1:0] TRIGGER_US_RESET = TRIG_W'(10);
  localparam logic [TOUT_W-1:0] TIMEOUT_US_RESET = TOUT_W'(58309);

  typedef enum logic [IDX_W-1:0] {
    REG_ENABLE  = 2'd0,
    REG_TRIGGER = 2'd1,
    REG_TIMEOUT = 2'd2,
    REG_NONE    = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_TRIG_OFF  = 2'd0,
    PH_TRIG_ON   = 2'd1,
    PH_WAITING   = 2'd2,
    PH_MEASURING = 2'd3
  } phase_t;

endpackage

// ===== design/ultrasonic_ranger_controller.sv =====
// ----------------------------------------------------------------------------
// ultrasonic_ranger_controller
// Trigger/echo ranger sequencer: one request per microsecond tick, one result
// per request with trigger drive, last echo width and distance.
// ----------------------------------------------------------------------------
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------------------
//  echo     | echo_valid / echo_ready    | echo_level
//  result   | result_valid / result_ready| trigger_level, measurement_valid,
//           |                            | echo_width_us, distance_q8,
//           |                            | new_measurement
//  config   | cfg_we                     | cfg_index, cfg_data
//
//  one request per cycle while echo_ready is high; its result is registered
//  into the output register at acceptance
//  the path per request is one saturating increment, the phase compares and
//  a 24 x 11 bit multiply for the distance
//  echo_ready stays high while the result register is empty or being drained
//  synchronous reset clears phase, counters, measurement and result valid
// ----------------------------------------------------------------------------
module ultrasonic_ranger_controller
  import urc_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]    cfg_data,
  input  logic                echo_valid,
  output logic                echo_ready,
  input  logic                echo_level,
  output logic                result_valid,
  input  logic                result_ready,
  output logic                trigger_level,
  output logic                measurement_valid,
  output logic [WIDTH_W-1:0]  echo_width_us,
  output logic [DIST_W-1:0]   distance_q8,
  output logic                new_measurement
);

  localparam int CMP_W  = (TIME_BITS > TOUT_W) ? TIME_BITS : TOUT_W;
  localparam int PROD_W = WIDTH_W + FACTOR_W;

  logic                enable;
  logic [TRIG_W-1:0]   trigger_us;
  logic [TOUT_W-1:0]   timeout_us;

  phase_t              phase, phase_next;
  logic [TIME_BITS-1:0] elapsed, elapsed_next, elapsed_inc;
  logic [WIDTH_W-1:0]  last_width, last_width_next;
  logic                have_meas, have_meas_next;
  logic                fresh_next;

  logic [CMP_W-1:0]    elapsed_ext;
  logic                over_timeout, over_trigger;
  logic [WIDTH_W-1:0]  width_sat;
  logic [PROD_W-1:0]   product;
  logic                accept;

  assign echo_ready = !result_valid || result_ready;
  assign accept     = echo_valid && echo_ready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      enable     <= 1'b0;
      trigger_us <= TRIGGER_US_RESET;
      timeout_us <= TIMEOUT_US_RESET;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_ENABLE:  enable     <= cfg_data[0];
        REG_TRIGGER: trigger_us <= cfg_data[TRIG_W-1:0];
        REG_TIMEOUT: timeout_us <= cfg_data[TOUT_W-1:0];
        default: ;
      endcase
    end
  end

  // saturating tick counter and compares
  assign elapsed_inc  = (&elapsed) ? elapsed : elapsed + 1'b1;
  assign elapsed_ext  = CMP_W'(elapsed_inc);
  assign over_timeout = elapsed_ext > CMP_W'(timeout_us);
  assign over_trigger = elapsed_ext > CMP_W'(trigger_us);
  assign width_sat    = (elapsed_ext > CMP_W'({WIDTH_W{1'b1}})) ?
                        {WIDTH_W{1'b1}} : WIDTH_W'(elapsed_ext);

  always_comb begin
    phase_next      = phase;
    elapsed_next    = elapsed_inc;
    last_width_next = last_width;
    have_meas_next  = have_meas;
    fresh_next      = 1'b0;
    if (!enable) begin
      phase_next      = PH_TRIG_OFF;
      elapsed_next    = '0;
      last_width_next = '0;
      have_meas_next  = 1'b0;
    end else begin
      case (phase)
        PH_TRIG_OFF: begin
          if (over_timeout) begin
            phase_next   = PH_TRIG_ON;
            elapsed_next = '0;
          end
        end
        PH_TRIG_ON: begin
          if (over_trigger) begin
            phase_next   = PH_WAITING;
            elapsed_next = '0;
          end
        end
        PH_WAITING: begin
          if (echo_level) begin
            phase_next   = PH_MEASURING;
            elapsed_next = '0;
          end else if (over_timeout) begin
            phase_next   = PH_TRIG_ON;
            elapsed_next = '0;
          end
        end
        PH_MEASURING: begin
          if (!echo_level) begin
            last_width_next = width_sat;
            have_meas_next  = 1'b1;
            fresh_next      = 1'b1;
            phase_next      = PH_TRIG_ON;
            elapsed_next    = '0;
          end
        end
        default: begin
          phase_next = PH_TRIG_OFF;
        end
      endcase
    end
  end

  assign product = PROD_W'(last_width_next) * PROD_W'(DIST_FACTOR);

  // ranger state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_TRIG_OFF;
      elapsed    <= '0;
      last_width <= '0;
      have_meas  <= 1'b0;
    end else if (accept) begin
      phase      <= phase_next;
      elapsed    <= elapsed_next;
      last_width <= last_width_next;
      have_meas  <= have_meas_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (accept) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      trigger_level     <= (phase_next == PH_TRIG_ON);
      measurement_valid <= have_meas_next;
      echo_width_us     <= last_width_next;
      distance_q8       <= product[PROD_W-1:DIST_SHIFT];
      new_measurement   <= fresh_next;
    end
  end

  a_fresh_raises_trigger : assert property (@(posedge clk) disable iff (rst)
    (result_valid && new_measurement) |-> (trigger_level && measurement_valid))
    else $error("new measurement without trigger or valid flag");

  a_invalid_reads_zero : assert property (@(posedge clk) disable iff (rst)
    (result_valid && !measurement_valid) |-> (echo_width_us == '0))
    else $error("width nonzero while measurement invalid");

  a_disabled_result : assert property (@(posedge clk) disable iff (rst)
    (accept && !enable) |=> (result_valid && !trigger_level && !measurement_valid
                              && !new_measurement))
    else $error("disabled tick gave a live result");

  a_capture_sets_have : assert property (@(posedge clk) disable iff (rst)
    (accept && enable && phase == PH_MEASURING) |=>
      (phase == PH_MEASURING || (phase == PH_TRIG_ON && have_meas)))
    else $error("measuring left without capture");

endmodule
